@@ rtl/core/qfb_pkg.sv @@
// Types, constants and helper functions shared by the query frame builder.
`default_nettype none

package qfb_pkg;

   localparam int unsigned IDX_W = 4;

   // Byte positions within a frame
   localparam logic [IDX_W-1:0] IDX_STX     = 4'd0;
   localparam logic [IDX_W-1:0] IDX_NODE    = 4'd1;
   localparam logic [IDX_W-1:0] IDX_TYPE_HI = 4'd2;
   localparam logic [IDX_W-1:0] IDX_TYPE_LO = 4'd3;
   localparam logic [IDX_W-1:0] IDX_TAG     = 4'd4;
   localparam logic [IDX_W-1:0] IDX_AXIS    = 4'd5;
   localparam logic [IDX_W-1:0] IDX_COUNT   = 4'd6;
   localparam logic [IDX_W-1:0] IDX_ENQ     = 4'd7;
   localparam logic [IDX_W-1:0] IDX_CRC_HI  = 4'd8;
   localparam logic [IDX_W-1:0] IDX_CRC_LO  = 4'd9;

   localparam logic [7:0]  BYTE_STX   = 8'h02;
   localparam logic [7:0]  BYTE_ENQ   = 8'h05;
   localparam logic [7:0]  ZERO_SUB   = 8'h78;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_A     = 8'h61;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   typedef struct packed {
      logic [3:0] node_id;
      logic [7:0] message_type;
      logic [3:0] tag_value;
      logic [3:0] first_axis;
      logic [3:0] axis_count;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
   } rsp_payload_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib <= 4'd9) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_A + (wide - 8'd10);
   endfunction

   // One byte of reflected CRC-16 (eight shift steps)
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/qfb_byte_sel.sv @@
// Selects the frame byte for a given position from the request fields and CRC.
`default_nettype none

module qfb_byte_sel (
   input  wire qfb_pkg::req_payload_type     fields,
   input  wire logic [qfb_pkg::IDX_W-1:0]    idx,
   input  wire logic [15:0]                  crc,
   output qfb_pkg::rsp_payload_type          word
);

   logic [7:0] crc_hi;
   logic [7:0] crc_lo;

   // a zero CRC byte goes out as 'x'
   assign crc_hi = (crc[15:8] == 8'h00) ? qfb_pkg::ZERO_SUB : crc[15:8];
   assign crc_lo = (crc[7:0] == 8'h00) ? qfb_pkg::ZERO_SUB : crc[7:0];

   always_comb begin
      word.frame_last = (idx == qfb_pkg::IDX_CRC_LO);
      case (idx)
         qfb_pkg::IDX_STX:     word.frame_byte = qfb_pkg::BYTE_STX;
         qfb_pkg::IDX_NODE:    word.frame_byte = qfb_pkg::hex_char(fields.node_id);
         qfb_pkg::IDX_TYPE_HI: word.frame_byte = qfb_pkg::hex_char(fields.message_type[7:4]);
         qfb_pkg::IDX_TYPE_LO: word.frame_byte = qfb_pkg::hex_char(fields.message_type[3:0]);
         qfb_pkg::IDX_TAG:     word.frame_byte = qfb_pkg::hex_char(fields.tag_value);
         qfb_pkg::IDX_AXIS:    word.frame_byte = qfb_pkg::hex_char(fields.first_axis);
         qfb_pkg::IDX_COUNT:   word.frame_byte = qfb_pkg::hex_char(fields.axis_count);
         qfb_pkg::IDX_ENQ:     word.frame_byte = qfb_pkg::BYTE_ENQ;
         qfb_pkg::IDX_CRC_HI:  word.frame_byte = crc_hi;
         qfb_pkg::IDX_CRC_LO:  word.frame_byte = crc_lo;
         default:              word.frame_byte = 8'h00;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/query_frame_builder_unit.sv @@
// Query frame builder: one request in, ten-byte framed query with CRC out.
// A taken request is registered, then each byte is registered in rsp_payload.
// Throughput: one frame byte per cycle while rsp is not stalled; a new request
//   enters as the last byte loads; the CRC folds in bytes STX to ENQ as sent.
// Reset (synchronous, active high) clears the frame sequencer and the output valid.
`default_nettype none

module query_frame_builder_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire qfb_pkg::req_payload_type   req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output qfb_pkg::rsp_payload_type        rsp_payload
);

   logic                          busy_ff, busy_in;
   logic [qfb_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [15:0]                   crc_ff, crc_in;
   qfb_pkg::req_payload_type      fields_ff, fields_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   qfb_pkg::rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   qfb_pkg::rsp_payload_type      cur_word;
   logic                          out_adv;
   logic                          load;
   logic                          finishing;
   logic                          req_take;

   qfb_byte_sel u_byte_sel (
      .fields (fields_ff),
      .idx    (idx_ff),
      .crc    (crc_ff),
      .word   (cur_word)
   );

   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign load      = busy_ff && out_adv;
   assign finishing = load && (idx_ff == qfb_pkg::IDX_CRC_LO);
   // next request may enter while the last word of the current frame loads
   assign req_stall = busy_ff && !finishing;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      busy_in        = busy_ff;
      idx_in         = idx_ff;
      crc_in         = crc_ff;
      fields_in      = fields_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (out_adv) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = cur_word;
         idx_in         = idx_ff + 4'd1;
         if (idx_ff <= qfb_pkg::IDX_ENQ) begin
            crc_in = qfb_pkg::crc_byte(crc_ff, cur_word.frame_byte);
         end
      end
      if (finishing) begin
         busy_in = 1'b0;
      end
      if (req_take) begin
         busy_in   = 1'b1;
         idx_in    = qfb_pkg::IDX_STX;
         crc_in    = qfb_pkg::CRC_INIT;
         fields_in = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= qfb_pkg::IDX_STX;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff         <= crc_in;
      fields_ff      <= fields_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

@@ rtl/core/qfb_checker.sv @@
// Port-level assertions for the query frame builder, bound to the top level.
`default_nettype none

module qfb_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire qfb_pkg::rsp_payload_type   rsp_payload
);

   // a held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp word changed while stalled");

   // a taken request occupies the builder for the next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while frame just started");

   // the low CRC byte never goes out as zero
   a_last_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_last |-> rsp_payload.frame_byte != 8'h00)
      else $error("last frame byte is zero");

   // nothing on the result side right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind query_frame_builder_unit qfb_checker u_qfb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

@@ tb/query_frame_builder_unit_tb.sv @@
// Self-checking testbench for query_frame_builder_unit: requests in, framed query bytes checked.
module query_frame_builder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      qfb_pkg::req_payload_type word;
      bit                       drain_first;   // hold this word back until every frame is out
   } request_slot_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   qfb_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   qfb_pkg::rsp_payload_type rsp_payload;

   request_slot_type         requests_pending [$];
   qfb_pkg::rsp_payload_type frame_bytes_due [$];
   int                       mismatch_count      = 0;
   int                       send_gap_left       = 0;
   int                       receiver_stall_left = 0;
   int unsigned              tick                = 0;

   query_frame_builder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      tick <= tick + 1;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + {4'h0, nib};
      return 8'h61 + {4'h0, nib} - 8'd10;
   endfunction

   // Bytes 0..7 of the frame: the part covered by the CRC
   function automatic logic [7:0] head_byte(input qfb_pkg::req_payload_type q,
                                            input logic [3:0] pos);
      case (pos)
         qfb_pkg::IDX_STX:     return qfb_pkg::BYTE_STX;
         qfb_pkg::IDX_NODE:    return ascii_hex(q.node_id);
         qfb_pkg::IDX_TYPE_HI: return ascii_hex(q.message_type[7:4]);
         qfb_pkg::IDX_TYPE_LO: return ascii_hex(q.message_type[3:0]);
         qfb_pkg::IDX_TAG:     return ascii_hex(q.tag_value);
         qfb_pkg::IDX_AXIS:    return ascii_hex(q.first_axis);
         qfb_pkg::IDX_COUNT:   return ascii_hex(q.axis_count);
         default:              return qfb_pkg::BYTE_ENQ;
      endcase
   endfunction

   // CRC-16/MODBUS over the head, before zero-byte substitution
   function automatic logic [15:0] head_crc(input qfb_pkg::req_payload_type q);
      logic [15:0] acc;
      acc = qfb_pkg::CRC_INIT;
      for (int pos = 0; pos < 8; pos++) begin
         acc ^= {8'h00, head_byte(q, 4'(pos))};
         repeat (8) acc = acc[0] ? ((acc >> 1) ^ qfb_pkg::CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

   task automatic queue_frame_bytes(input qfb_pkg::req_payload_type q);
      logic [15:0]              crc;
      qfb_pkg::rsp_payload_type b;
      crc = head_crc(q);
      for (int pos = 0; pos < 8; pos++) begin
         b.frame_byte = head_byte(q, 4'(pos));
         b.frame_last = 1'b0;
         frame_bytes_due = {frame_bytes_due, b};
      end
      b.frame_byte = (crc[15:8] == 8'h00) ? qfb_pkg::ZERO_SUB : crc[15:8];
      b.frame_last = 1'b0;
      frame_bytes_due = {frame_bytes_due, b};
      b.frame_byte = (crc[7:0] == 8'h00) ? qfb_pkg::ZERO_SUB : crc[7:0];
      b.frame_last = 1'b1;
      frame_bytes_due = {frame_bytes_due, b};
   endtask

   // ---------------------------------------------------------------- idling

   // Mostly short gaps, now and then a long one
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Periodic stretches where neither side idles
   function automatic bit quiet_window();
      return (tick % 700) < 150;
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      request_slot_type slot;
      bit               free;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         free = !req_valid;
         if (req_valid && !req_stall) begin
            queue_frame_bytes(req_payload);
            send_gap_left = quiet_window() ? 0 : idle_span();
            free = 1'b1;
         end
         if (free) begin
            if (send_gap_left > 0) begin
               send_gap_left--;
               req_valid <= 1'b0;
            end else if (requests_pending.size() != 0 &&
                         (!requests_pending[0].drain_first || frame_bytes_due.size() == 0)) begin
               slot = requests_pending.pop_front();
               req_payload <= slot.word;
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      qfb_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected word: byte %02h last %0b", $time,
                           rsp_payload.frame_byte, rsp_payload.frame_last);
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_payload.frame_byte !== want.frame_byte ||
                   rsp_payload.frame_last !== want.frame_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                              $time, want.frame_byte, want.frame_last,
                              rsp_payload.frame_byte, rsp_payload.frame_last);
               end
            end
         end
         if (quiet_window()) begin
            receiver_stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (receiver_stall_left > 0) begin
            receiver_stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0) receiver_stall_left = idle_span();
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_request(input qfb_pkg::req_payload_type q, input bit drain);
      request_slot_type slot;
      slot.word        = q;
      slot.drain_first = drain;
      requests_pending = {requests_pending, slot};
   endtask

   initial begin
      qfb_pkg::req_payload_type q;
      logic [15:0]              crc;
      bit                       hi_done;
      bit                       lo_done;
      // every hex digit in every character position
      for (int i = 0; i < 16; i++) begin
         q.node_id      = 4'(i);
         q.message_type = {4'(i), 4'(15 - i)};
         q.tag_value    = 4'(15 - i);
         q.first_axis   = 4'(i);
         q.axis_count   = 4'(i + 5);
         add_request(q, 1'b0);
      end
      add_request('0, 1'b0);
      add_request('1, 1'b0);
      // requests whose CRC has a zero high byte and a zero low byte
      hi_done = 1'b0;
      lo_done = 1'b0;
      for (int v = 0; v < (1 << 24) && !(hi_done && lo_done); v++) begin
         q   = v[23:0];
         crc = head_crc(q);
         if (!hi_done && crc[15:8] == 8'h00) begin
            hi_done = 1'b1;
            add_request(q, 1'b0);
         end
         if (!lo_done && crc[7:0] == 8'h00) begin
            lo_done = 1'b1;
            add_request(q, 1'b0);
         end
      end
      for (int n = 0; n < 90; n++) begin
         q = 24'($urandom);
         if ($urandom_range(0, 9) == 0) q.message_type = $urandom_range(0, 1) ? 8'hff : 8'h00;
         if ($urandom_range(0, 9) == 0) q.node_id = $urandom_range(0, 1) ? 4'hf : 4'h0;
         add_request(q, n == 0 || $urandom_range(0, 19) == 0);
      end

      while (requests_pending.size() != 0) @(posedge clock);
      // let the last word reach req_valid before watching for the drain
      @(posedge clock);
      while (req_valid || frame_bytes_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
         $display("** query_frame_builder_unit: PASSED **");
      end else begin
         $display("** query_frame_builder_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("%0t: timeout", $time);
      $display("** query_frame_builder_unit: FAILED **");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/qfb_pkg.sv
rtl/core/qfb_byte_sel.sv
rtl/core/query_frame_builder_unit.sv
rtl/core/qfb_checker.sv
tb/query_frame_builder_unit_tb.sv
